FILE: rtl/core/kmuf_pkg.sv
// Package for the Kruskal maze union-find core: payload structs, micro-op codes
// and the command and status structs that pass between controller and datapath.
// No dependencies.
package kmuf_pkg;

    localparam int KMUF_MAX_SIDE = 32;
    localparam int RANK_W        = 4;
    localparam int CFG_W         = 6;
    localparam int SIDE_W        = 7;
    localparam int COORD_W       = 5;
    localparam int WALL_W        = 7;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam logic [CFG_W-1:0]  CFG_RESET = 6'd32;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               direction;
    } t_in_item;

    typedef struct packed {
        logic              carved;
        logic [WALL_W-1:0] wall_row;
        logic [WALL_W-1:0] wall_col;
        logic              bad_edge;
    } t_out_item;

    // Datapath micro-operations.
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_CLEAR  = 4'd2;
    localparam logic [3:0] OP_READ_X = 4'd3;
    localparam logic [3:0] OP_STEP   = 4'd4;
    localparam logic [3:0] OP_HALVE  = 4'd5;
    localparam logic [3:0] OP_SAVE_A = 4'd6;
    localparam logic [3:0] OP_SAVE_B = 4'd7;
    localparam logic [3:0] OP_RANK   = 4'd8;
    localparam logic [3:0] OP_MERGE  = 4'd9;
    localparam logic [3:0] OP_EMIT   = 4'd10;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic bad;
        logic is_root;
        logic same;
        logic clear_last;
    } t_status;

endpackage

FILE: rtl/core/kruskal_maze_union_find_core.sv
// Top level of the Kruskal maze union-find core: controller and datapath.
// Depends on kmuf_pkg, kmuf_controller and kmuf_datapath.
//
// Channel   Direction  Handshake                     Payload
// command   in         start && !busy                i_item (t_in_item)
// result    out        o_result_valid, one cycle     o_result (t_out_item)
// config    in         i_cfg_valid && o_cfg_ready    i_cfg_data (cells_per_side)
//
// A carved edge runs two root walks with path halving over the parent memory,
// then reads both ranks and merges the two roots; an edge within one set skips
// the rank read and the merge and emits its result after the walks.
// An edge off the grid gives its result without a root walk. A restart gives its result
// and then stays busy for a clearing sweep over all MAX_SIDE*MAX_SIDE cells.
// After reset the same sweep runs before the first transaction is taken.
// The receiver cannot stall; configuration is always ready.
module kruskal_maze_union_find_core
    import kmuf_pkg::*;
#(
    parameter int MAX_SIDE = KMUF_MAX_SIDE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    output logic             o_result_valid,
    output t_out_item        o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    kmuf_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    kmuf_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

FILE: rtl/core/kmuf_datapath.sv
// Datapath of the Kruskal maze union-find core: parent and rank memories,
// walk registers, side register and result register. Depends on kmuf_pkg.
module kmuf_datapath
    import kmuf_pkg::*;
#(
    parameter int MAX_SIDE = KMUF_MAX_SIDE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_in_item         i_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_status          o_status,
    output logic             o_result_valid,
    output t_out_item        o_result
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int IW    = $clog2(CELLS);
    localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(MAX_SIDE);

    logic [IW-1:0]     r_parent [CELLS];
    logic [RANK_W-1:0] r_rank   [CELLS];

    logic [CFG_W-1:0]   r_cfg;
    logic [IW-1:0]      r_cnt;
    logic [IW-1:0]      r_x;
    logic [IW-1:0]      r_pdata;
    logic [IW-1:0]      r_ra;
    logic [IW-1:0]      r_rb;
    logic [IW-1:0]      r_idx_b;
    logic [RANK_W-1:0]  r_rka;
    logic [RANK_W-1:0]  r_rkb;
    logic               r_mode;
    logic               r_bad;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic               r_dir;
    logic               r_valid;
    t_out_item          r_out;

    logic [SIDE_W-1:0]  side;
    logic [SIDE_W-1:0]  nr;
    logic [SIDE_W-1:0]  nc;
    logic               bad;
    logic [11:0]        idx_a_full;
    logic [11:0]        idx_b_full;
    logic               swap;
    logic [IW-1:0]      hi;
    logic [IW-1:0]      lo;
    logic [RANK_W-1:0]  hi_rank;
    logic               bump;

    always_comb begin
        side = (SIDE_W'(r_cfg) > SIDE_LIMIT) ? SIDE_LIMIT : SIDE_W'(r_cfg);
        nr   = SIDE_W'(i_item.cell_row) + SIDE_W'(i_item.direction);
        nc   = SIDE_W'(i_item.cell_col) + {{(SIDE_W-1){1'b0}}, ~i_item.direction};
        bad  = (SIDE_W'(i_item.cell_row) >= side) || (SIDE_W'(i_item.cell_col) >= side)
            || (nr >= side) || (nc >= side);
        idx_a_full = 12'(i_item.cell_row) * 12'(side) + 12'(i_item.cell_col);
        idx_b_full = 12'(nr) * 12'(side) + 12'(nc);
        swap    = r_rka < r_rkb;
        hi      = swap ? r_rb : r_ra;
        lo      = swap ? r_ra : r_rb;
        hi_rank = swap ? r_rkb : r_rka;
        bump    = (r_rka == r_rkb) && (r_rka < RANK_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= CFG_RESET;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_valid <= (i_cmd.op == OP_EMIT) || (i_cmd.op == OP_MERGE);
            if (i_cmd.op == OP_CLEAR) begin
                r_cnt <= (r_cnt == IW'(CELLS - 1)) ? '0 : r_cnt + 1'b1;
            end
        end
    end

    // Memories and walk registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode  <= i_item.mode;
                r_bad   <= bad;
                r_row   <= i_item.cell_row;
                r_col   <= i_item.cell_col;
                r_dir   <= i_item.direction;
                r_x     <= idx_a_full[IW-1:0];
                r_idx_b <= idx_b_full[IW-1:0];
            end
            OP_CLEAR: begin
                r_parent[r_cnt] <= r_cnt;
                r_rank[r_cnt]   <= '0;
            end
            OP_READ_X: begin
                r_pdata <= r_parent[r_x];
            end
            OP_STEP: begin
                r_pdata <= r_parent[r_pdata];
            end
            OP_HALVE: begin
                // Path halving: point x at its grandparent and move on to it.
                r_parent[r_x] <= r_pdata;
                r_x           <= r_pdata;
                r_pdata       <= r_parent[r_pdata];
            end
            OP_SAVE_A: begin
                r_ra    <= r_x;
                r_x     <= r_idx_b;
                r_pdata <= r_parent[r_idx_b];
            end
            OP_SAVE_B: begin
                r_rb <= r_x;
            end
            OP_RANK: begin
                r_rka <= r_rank[r_ra];
                r_rkb <= r_rank[r_rb];
            end
            OP_MERGE: begin
                r_parent[lo] <= hi;
                if (bump) begin
                    r_rank[hi] <= hi_rank + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_EMIT: begin
                r_out.carved   <= 1'b0;
                r_out.wall_row <= '0;
                r_out.wall_col <= '0;
                r_out.bad_edge <= r_bad && !r_mode;
            end
            OP_MERGE: begin
                r_out.carved   <= 1'b1;
                r_out.wall_row <= {1'b0, r_row, 1'b0} + WALL_W'(1) + WALL_W'(r_dir);
                r_out.wall_col <= {1'b0, r_col, 1'b0} + WALL_W'(2) - WALL_W'(r_dir);
                r_out.bad_edge <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_status.mode       = r_mode;
    assign o_status.bad        = r_bad;
    assign o_status.is_root    = r_pdata == r_x;
    assign o_status.same       = r_ra == r_rb;
    assign o_status.clear_last = r_cnt == IW'(CELLS - 1);
    assign o_result_valid      = r_valid;
    assign o_result            = r_out;

    a_carved_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_out.carved && r_out.bad_edge))
        else $error("carved and bad_edge both set");
    a_wall_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.carved) |-> (r_out.wall_row[0] != r_out.wall_col[0]))
        else $error("opened wall is not between two cells");
    a_merge_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_MERGE) |-> (r_ra != r_rb))
        else $error("merge of a set with itself");

endmodule

FILE: rtl/core/kmuf_controller.sv
// Controller of the Kruskal maze union-find core: sequences the clearing
// sweep, the two root walks and the merge. Depends on kmuf_pkg.
module kmuf_controller
    import kmuf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output logic    o_busy,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_HALVE  = 3'd4;
    localparam logic [2:0] S_RANK   = 3'd5;
    localparam logic [2:0] S_MERGE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_phase_b;
    logic       n_phase_b;

    always_comb begin
        n_state   = r_state;
        n_phase_b = r_phase_b;
        o_cmd.op  = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DECIDE: begin
                if (i_status.mode) begin
                    // The restart result goes out at once; the sweep follows.
                    o_cmd.op = OP_EMIT;
                    n_state  = S_CLEAR;
                end else if (i_status.bad) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op  = OP_READ_X;
                    n_phase_b = 1'b0;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.is_root) begin
                    o_cmd.op = OP_STEP;
                    n_state  = S_HALVE;
                end else if (!r_phase_b) begin
                    o_cmd.op  = OP_SAVE_A;
                    n_phase_b = 1'b1;
                end else begin
                    o_cmd.op = OP_SAVE_B;
                    n_state  = S_RANK;
                end
            end
            S_HALVE: begin
                o_cmd.op = OP_HALVE;
                n_state  = S_CHECK;
            end
            S_RANK: begin
                if (i_status.same) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = OP_RANK;
                    n_state  = S_MERGE;
                end
            end
            S_MERGE: begin
                o_cmd.op = OP_MERGE;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_phase_b <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase_b <= n_phase_b;
        end
    end

    assign o_busy = r_state != S_IDLE;

endmodule
